/* hw/rtl/icp_pkg.sv */
// Shared constants, payload structs and state encodings for the cycle permuter.
package icp_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int IDX_W        = 6;   // element index / permutation entry width
    localparam int CNT_W        = 7;   // batch count, holds MAX_ELEMENTS itself
    localparam int WORD_W       = 64;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic [IDX_W-1:0]  perm_entry;
        logic              last_in;
    } icp_in_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic              last_out;
        logic              bad_perm;
    } icp_out_t;

    // Memory requests from the cycle walker
    typedef struct packed {
        logic [IDX_W-1:0]  d_raddr;
        logic              d_we;
        logic [IDX_W-1:0]  d_waddr;
        logic [WORD_W-1:0] d_wdata;
        logic [IDX_W-1:0]  p_raddr;
    } icp_mem_req_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_WALK,
        ST_EMIT_RD,
        ST_EMIT_LD
    } icp_state_t;

    typedef enum logic [2:0] {
        WK_IDLE,
        WK_LEAD,
        WK_SRCH,
        WK_PK,
        WK_T,
        WK_MV,
        WK_END
    } walk_state_t;

endpackage

/* hw/rtl/icp_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
module icp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/icp_walker.sv */
// Cycle-leader sequencer: walks each permutation cycle and moves words in place.
module icp_walker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [icp_pkg::CNT_W-1:0]  n,
    input  logic                       inv,
    input  logic [icp_pkg::IDX_W-1:0]  p_rdata,
    input  logic [icp_pkg::WORD_W-1:0] d_rdata,
    output icp_pkg::icp_mem_req_t      req,
    output logic                       done
);
    import icp_pkg::*;

    walk_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  pk_reg, pk_next;
    logic [WORD_W-1:0] t_reg, t_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              inv_reg, inv_next;
    logic              last_i;
    logic [IDX_W-1:0]  i_inc;

    assign last_i = (({1'b0, i_reg} + CNT_W'(1)) == n_reg);
    assign i_inc  = i_reg + IDX_W'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            WK_IDLE: begin
                if (start) state_next = WK_LEAD;
            end
            WK_LEAD: state_next = WK_SRCH;
            WK_SRCH: begin
                if (p_rdata > i_reg) begin
                    state_next = WK_SRCH;
                end else if (p_rdata != i_reg) begin
                    state_next = last_i ? WK_IDLE : WK_LEAD;
                end else begin
                    state_next = WK_PK;
                end
            end
            WK_PK: begin
                if (p_rdata == i_reg) begin
                    state_next = last_i ? WK_IDLE : WK_LEAD;
                end else begin
                    state_next = WK_T;
                end
            end
            WK_T: state_next = WK_MV;
            WK_MV: begin
                if (p_rdata == i_reg) state_next = WK_END;
            end
            WK_END: state_next = last_i ? WK_IDLE : WK_LEAD;
            default: state_next = WK_IDLE;
        endcase
    end

    // datapath and memory requests
    always_comb begin
        i_next      = i_reg;
        k_next      = k_reg;
        pk_next     = pk_reg;
        t_next      = t_reg;
        n_next      = n_reg;
        inv_next    = inv_reg;
        req.d_raddr = i_reg;
        req.p_raddr = i_reg;
        req.d_we    = 1'b0;
        req.d_waddr = k_reg;
        req.d_wdata = t_reg;
        unique case (state_reg)
            WK_IDLE: begin
                if (start) begin
                    n_next   = n;
                    inv_next = inv;
                    i_next   = '0;
                end
            end
            WK_LEAD: req.p_raddr = i_reg;
            WK_SRCH: begin
                // follow the chain while it stays above the candidate leader
                req.p_raddr = p_rdata;
                if (p_rdata < i_reg) i_next = i_inc;
            end
            WK_PK: begin
                if (p_rdata == i_reg) begin
                    i_next = i_inc;     // fixed point
                end else begin
                    pk_next     = p_rdata;
                    k_next      = i_reg;
                    req.d_raddr = i_reg;
                end
            end
            WK_T: begin
                t_next      = d_rdata;
                req.d_raddr = pk_reg;
                req.p_raddr = pk_reg;
            end
            WK_MV: begin
                req.d_we = 1'b1;
                if (inv_reg) begin
                    req.d_waddr = pk_reg;
                    req.d_wdata = t_reg;
                    t_next      = d_rdata;
                end else begin
                    req.d_waddr = k_reg;
                    req.d_wdata = d_rdata;
                    k_next      = pk_reg;
                end
                pk_next     = p_rdata;
                req.d_raddr = p_rdata;
                req.p_raddr = p_rdata;
            end
            WK_END: begin
                req.d_we    = 1'b1;
                req.d_waddr = inv_reg ? i_reg : k_reg;
                req.d_wdata = t_reg;
                i_next      = i_inc;
            end
            default: ;
        endcase
    end

    assign done = (state_reg != WK_IDLE) && (state_next == WK_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= WK_IDLE;
            i_reg     <= '0;
            n_reg     <= '0;
            inv_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            n_reg     <= n_next;
            inv_reg   <= inv_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg  <= k_next;
        pk_reg <= pk_next;
        t_reg  <= t_next;
    end

endmodule

/* hw/rtl/inplace_cycle_permuter.sv */
// Top level: batch loader, permutation check, cycle walk and ordered emission.
//
// Usage. Words arrive on the s_ channel (valid/ready), one word a cycle, each
// carrying a data word, its permutation entry and a last flag. The word with
// last_in set, or the 64th word, closes the batch. s_ready then drops while
// the batch is permuted in place (forward x[i] <- x[p[i]], inverse
// x[p[i]] <- x[i], chosen by inverse_mode at the close) and emitted on the
// m_ channel in index order, last_out on the final word.
// Duplicate or out-of-range entries are caught while loading: such a batch
// skips the walk and goes out unchanged with bad_perm on every word.
// After the close each index is taken in turn: a leader search follows its
// chain through the entries, and an index that leads a cycle of two or more
// entries then has the words of that cycle moved; the search through the
// single permutation read port dominates for long cycles. Emission then
// reads each word and loads it into the output register before reading the
// next. The output register frees the loader: the next batch may start
// loading while the final word still waits.
// When the receiver stalls, the word in the output register holds and the
// read of the next word waits. inverse_mode is written on cfg_ (always
// ready). Reset empties the batch, clears the output and sets forward mode.
module inplace_cycle_permuter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  icp_pkg::icp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output icp_pkg::icp_out_t m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data
);
    import icp_pkg::*;

    icp_state_t        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [MAX_ELEMENTS-1:0] seen_reg, seen_next;
    logic [IDX_W-1:0]  max_reg, max_next;
    logic              invalid_reg, invalid_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic              bad_reg, bad_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic              inverse_mode_reg, inverse_mode_next;
    logic              m_valid_reg, m_valid_next;
    icp_out_t          m_data_reg, m_data_next;

    logic              s_accept;
    logic [CNT_W-1:0]  count_inc;
    logic              closing;
    logic              dup;
    logic [IDX_W-1:0]  max_new;
    logic              bad_new;
    logic              out_free;
    logic              last_word;
    logic              walk_start;
    logic              walk_done;
    icp_mem_req_t      walk_req;

    // memory ports
    logic              d_we;
    logic [IDX_W-1:0]  d_waddr, d_raddr;
    logic [WORD_W-1:0] d_wdata, d_rdata;
    logic [IDX_W-1:0]  p_rdata;

    assign s_ready   = (state_reg == ST_LOAD);
    assign s_accept  = s_valid && s_ready;
    assign count_inc = count_reg + CNT_W'(1);
    assign closing   = s_data.last_in || (count_inc == CNT_W'(MAX_ELEMENTS));
    assign dup       = seen_reg[s_data.perm_entry];
    assign max_new   = (s_data.perm_entry > max_reg) ? s_data.perm_entry : max_reg;
    // out of range: the largest entry of the batch reaches the count
    assign bad_new   = invalid_reg || dup || ({1'b0, max_new} >= count_inc);
    assign walk_start = s_accept && closing && !bad_new;
    assign out_free  = !m_valid_reg || m_ready;
    assign last_word = (({1'b0, j_reg} + CNT_W'(1)) == n_reg);

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // write port: loader in ST_LOAD, walker otherwise
    assign d_we    = s_accept || walk_req.d_we;
    assign d_waddr = (state_reg == ST_LOAD) ? count_reg[IDX_W-1:0] : walk_req.d_waddr;
    assign d_wdata = (state_reg == ST_LOAD) ? s_data.data_word : walk_req.d_wdata;
    assign d_raddr = (state_reg == ST_EMIT_RD || state_reg == ST_EMIT_LD) ?
                     j_reg : walk_req.d_raddr;

    icp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_data_ram (
        .aclk  (aclk),
        .we    (d_we),
        .waddr (d_waddr),
        .wdata (d_wdata),
        .raddr (d_raddr),
        .rdata (d_rdata)
    );

    icp_ram #(
        .WIDTH (IDX_W),
        .DEPTH (MAX_ELEMENTS)
    ) u_perm_ram (
        .aclk  (aclk),
        .we    (s_accept),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (s_data.perm_entry),
        .raddr (walk_req.p_raddr),
        .rdata (p_rdata)
    );

    icp_walker u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (walk_start),
        .n       (count_inc),
        .inv     (inverse_mode_reg),
        .p_rdata (p_rdata),
        .d_rdata (d_rdata),
        .req     (walk_req),
        .done    (walk_done)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept && closing) state_next = bad_new ? ST_EMIT_RD : ST_WALK;
            end
            ST_WALK: begin
                if (walk_done) state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD: state_next = ST_EMIT_LD;
            ST_EMIT_LD: begin
                if (out_free) state_next = last_word ? ST_LOAD : ST_EMIT_RD;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // batch bookkeeping, output register and config
    always_comb begin
        count_next        = count_reg;
        seen_next         = seen_reg;
        max_next          = max_reg;
        invalid_next      = invalid_reg;
        n_next            = n_reg;
        bad_next          = bad_reg;
        j_next            = j_reg;
        m_data_next       = m_data_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        inverse_mode_next = cfg_valid ? cfg_data : inverse_mode_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (closing) begin
                        n_next       = count_inc;
                        bad_next     = bad_new;
                        count_next   = '0;
                        seen_next    = '0;
                        max_next     = '0;
                        invalid_next = 1'b0;
                        j_next       = '0;
                    end else begin
                        count_next                   = count_inc;
                        seen_next[s_data.perm_entry] = 1'b1;
                        max_next                     = max_new;
                        invalid_next                 = invalid_reg || dup;
                    end
                end
            end
            ST_EMIT_LD: begin
                if (out_free) begin
                    m_data_next.out_word = d_rdata;
                    m_data_next.last_out = last_word;
                    m_data_next.bad_perm = bad_reg;
                    m_valid_next         = 1'b1;
                    j_next               = j_reg + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            seen_reg         <= '0;
            max_reg          <= '0;
            invalid_reg      <= 1'b0;
            n_reg            <= '0;
            bad_reg          <= 1'b0;
            j_reg            <= '0;
            inverse_mode_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            seen_reg         <= seen_next;
            max_reg          <= max_next;
            invalid_reg      <= invalid_next;
            n_reg            <= n_next;
            bad_reg          <= bad_next;
            j_reg            <= j_next;
            inverse_mode_reg <= inverse_mode_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

endmodule
